// File: sv/source_text_lexer_defines.svh
// Assertion macros for the source text lexer checker.
`ifndef SOURCE_TEXT_LEXER_DEFINES_SVH
`define SOURCE_TEXT_LEXER_DEFINES_SVH

// Checked only while out of reset.
`define STL_ASSERT(LBL, CK, RN, PROP, MSG) \
	LBL: assert property (@(posedge CK) disable iff (!RN) PROP) else $error(MSG);

// Checked at every edge, reset included.
`define STL_ASSERT_ALWAYS(LBL, CK, PROP, MSG) \
	LBL: assert property (@(posedge CK) PROP) else $error(MSG);

`endif

// File: sv/stl_pkg.sv
// Types, token classes and word tables of the source text lexer.
package stl_pkg;

	localparam int MAX_WORD_CHARS = 9;
	localparam int PFX_IW = $clog2(MAX_WORD_CHARS);
	localparam int TXT_W = 8 * 16;

	typedef enum logic [3:0] {
		CLS_IDENT     = 4'd0,
		CLS_INTEGER   = 4'd1,
		CLS_KEYWORD   = 4'd2,
		CLS_OPERATOR  = 4'd3,
		CLS_BRACKET   = 4'd4,
		CLS_STATEMENT = 4'd5,
		CLS_TYPE      = 4'd6,
		CLS_VALUE     = 4'd7,
		CLS_UNKNOWN   = 4'd8
	} tok_class_t;

	typedef struct packed {
		tok_class_t  token_class;
		logic [31:0] token_start;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} tok_t;

	typedef struct packed {
		logic vld;
		tok_t tok;
	} slot_t;

	typedef struct packed {
		logic       hit;
		tok_class_t cls;
	} match_t;

	localparam int N_WORDS = 19;
	localparam logic [TXT_W-1:0] WORD_TXT [N_WORDS] = '{
		"not", "and", "or", "xor", "else", "fix", "in", "return", "to",
		"bind", "if", "while", "Boolean", "Character", "Integer", "String",
		"false", "lambda", "true"
	};
	localparam logic [4:0] WORD_LEN [N_WORDS] = '{
		5'd3, 5'd3, 5'd2, 5'd3, 5'd4, 5'd3, 5'd2, 5'd6, 5'd2,
		5'd4, 5'd2, 5'd5, 5'd7, 5'd9, 5'd7, 5'd6, 5'd5, 5'd6, 5'd4
	};
	localparam tok_class_t WORD_CLS [N_WORDS] = '{
		CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR,
		CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
		CLS_STATEMENT, CLS_STATEMENT, CLS_STATEMENT,
		CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE,
		CLS_VALUE, CLS_VALUE, CLS_VALUE
	};

	localparam int N_SYMS = 12;
	localparam logic [TXT_W-1:0] SYM_TXT [N_SYMS] = '{
		"+", "-", "*", "/", "<", ">", ":", "=", "<=", ">=", "!=", "->"
	};
	localparam logic [4:0] SYM_LEN [N_SYMS] = '{
		5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2
	};
	localparam tok_class_t SYM_CLS [N_SYMS] = '{
		CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR,
		CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR,
		CLS_OPERATOR, CLS_OPERATOR, CLS_OPERATOR, CLS_TYPE
	};

	// Table text is right-justified: char i of a word of length L sits at byte L-1-i.
	function automatic logic txt_match(input logic [8*MAX_WORD_CHARS-1:0] pfx,
			input logic [15:0] len, input logic [TXT_W-1:0] txt, input logic [4:0] wlen);
		logic ok;
		ok = (len == {11'd0, wlen}) && (int'(wlen) <= MAX_WORD_CHARS);
		for (int i = 0; i < MAX_WORD_CHARS; i++) begin
			if (i < int'(wlen))
				ok = ok && (pfx[8*i +: 8] == txt[8*(int'(wlen) - 1 - i) +: 8]);
		end
		return ok;
	endfunction

	function automatic match_t word_lookup(input logic [8*MAX_WORD_CHARS-1:0] pfx,
			input logic [15:0] len);
		match_t m;
		m = '{hit: 1'b0, cls: CLS_UNKNOWN};
		for (int e = N_WORDS - 1; e >= 0; e--) begin
			if (txt_match(pfx, len, WORD_TXT[e], WORD_LEN[e]))
				m = '{hit: 1'b1, cls: WORD_CLS[e]};
		end
		return m;
	endfunction

	function automatic match_t sym_lookup(input logic [8*MAX_WORD_CHARS-1:0] pfx,
			input logic [15:0] len);
		match_t m;
		m = '{hit: 1'b0, cls: CLS_UNKNOWN};
		for (int e = N_SYMS - 1; e >= 0; e--) begin
			if (txt_match(pfx, len, SYM_TXT[e], SYM_LEN[e]))
				m = '{hit: 1'b1, cls: SYM_CLS[e]};
		end
		return m;
	endfunction

endpackage

// File: sv/stl_core.sv
// Lexer state: chunk, comment and run tracking, token classification.
module stl_core import stl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output slot_t      slot0,
	output slot_t      slot1
);

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_WORD = 2'd1,
		K_SYM  = 2'd2
	} kind_t;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	logic [8*MAX_WORD_CHARS-1:0] pfx_q;
	kind_t       kind_q, kind_n;
	logic [15:0] len_q, len_n;
	logic [31:0] start_q, start_n;
	logic        digits_q, digits_n;
	logic        slash_q, slash_n;
	logic        chunk_q, chunk_n;
	logic        cmt_q, cmt_n;
	logic [15:0] line_q, line_n;
	logic [31:0] off_q, off_n;

	logic              pw;
	logic [PFX_IW-1:0] pidx;
	logic              do_flush, do_br;
	logic              is_dig, is_let, is_wb, is_br, is_sp, is_lf;
	logic [7:0]        b0;
	logic              b0_let;
	logic [15:0]       line_inc;
	match_t            wm, sm;
	tok_class_t        fl_cls;
	tok_t              fl_tok, br_tok;

	assign is_dig = (char_code >= "0") && (char_code <= "9");
	assign is_let = ((char_code >= "A") && (char_code <= "Z")) ||
		((char_code >= "a") && (char_code <= "z"));
	assign is_wb  = is_dig || is_let || (char_code == CH_UNDER);
	assign is_br  = (char_code == "(") || (char_code == ")") ||
		(char_code == "{") || (char_code == "}");
	assign is_lf  = (char_code == CH_LF);
	assign is_sp  = (char_code == CH_SP) || (char_code == CH_TAB) || is_lf;

	assign b0     = pfx_q[7:0];
	assign b0_let = ((b0 >= "A") && (b0 <= "Z")) || ((b0 >= "a") && (b0 <= "z"));
	assign line_inc = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;

	assign wm = word_lookup(pfx_q, len_q);
	assign sm = sym_lookup(pfx_q, len_q);

	always_comb begin
		if (kind_q == K_WORD)
			fl_cls = wm.hit ? wm.cls : (digits_q ? CLS_INTEGER :
				(b0_let ? CLS_IDENT : CLS_UNKNOWN));
		else
			fl_cls = sm.hit ? sm.cls : CLS_UNKNOWN;
	end

	assign fl_tok = '{token_class: fl_cls, token_start: start_q, token_length: len_q,
		line_number: line_q, last_of_run: !do_br};
	assign br_tok = '{token_class: CLS_BRACKET, token_start: off_q, token_length: 16'd1,
		line_number: line_q, last_of_run: 1'b1};

	always_comb begin
		kind_n   = kind_q;
		len_n    = len_q;
		start_n  = start_q;
		digits_n = digits_q;
		slash_n  = slash_q;
		chunk_n  = chunk_q;
		cmt_n    = cmt_q;
		line_n   = line_q;
		off_n    = off_q + 32'd1;
		pw       = 1'b0;
		pidx     = '0;
		do_flush = 1'b0;
		do_br    = 1'b0;
		if (end_of_input) begin
			do_flush = !cmt_q && (kind_q != K_NONE);
			kind_n   = K_NONE;
			len_n    = '0;
			start_n  = '0;
			digits_n = 1'b1;
			slash_n  = 1'b0;
			chunk_n  = 1'b0;
			cmt_n    = 1'b0;
			line_n   = 16'd1;
			off_n    = '0;
		end else if (cmt_q) begin
			if (is_lf) begin
				cmt_n  = 1'b0;
				line_n = line_inc;
			end
		end else if (is_sp) begin
			do_flush = (kind_q != K_NONE);
			kind_n   = K_NONE;
			len_n    = '0;
			digits_n = 1'b1;
			chunk_n  = 1'b0;
			slash_n  = 1'b0;
			if (is_lf)
				line_n = line_inc;
		end else if (slash_q && (char_code == CH_SLASH)) begin
			// comment opener: pending slash run is dropped
			kind_n   = K_NONE;
			len_n    = '0;
			digits_n = 1'b1;
			slash_n  = 1'b0;
			chunk_n  = 1'b0;
			cmt_n    = 1'b1;
		end else begin
			slash_n = !chunk_q && (char_code == CH_SLASH);
			chunk_n = 1'b1;
			if ((is_wb && (kind_q == K_WORD)) || (!is_wb && (kind_q == K_SYM))) begin
				if (len_q < 16'(MAX_WORD_CHARS)) begin
					pw   = 1'b1;
					pidx = len_q[PFX_IW-1:0];
				end
				if (len_q != 16'hFFFF)
					len_n = len_q + 16'd1;
				if (!is_dig)
					digits_n = 1'b0;
			end else begin
				do_flush = (kind_q != K_NONE);
				if (!is_wb && is_br) begin
					do_br    = 1'b1;
					kind_n   = K_NONE;
					len_n    = '0;
					digits_n = 1'b1;
				end else begin
					kind_n   = is_wb ? K_WORD : K_SYM;
					start_n  = off_q;
					len_n    = 16'd1;
					digits_n = is_dig;
					pw       = 1'b1;
					pidx     = '0;
				end
			end
		end
	end

	always_comb begin
		slot0.vld = in_valid && (do_flush || do_br);
		slot0.tok = do_flush ? fl_tok : br_tok;
		slot1.vld = in_valid && do_flush && do_br;
		slot1.tok = br_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= K_NONE;
			len_q    <= '0;
			start_q  <= '0;
			digits_q <= 1'b1;
			slash_q  <= 1'b0;
			chunk_q  <= 1'b0;
			cmt_q    <= 1'b0;
			line_q   <= 16'd1;
			off_q    <= '0;
		end else if (in_valid) begin
			kind_q   <= kind_n;
			len_q    <= len_n;
			start_q  <= start_n;
			digits_q <= digits_n;
			slash_q  <= slash_n;
			chunk_q  <= chunk_n;
			cmt_q    <= cmt_n;
			line_q   <= line_n;
			off_q    <= off_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && pw)
			pfx_q[8*pidx +: 8] <= char_code;
	end

endmodule

// File: sv/source_text_lexer.sv
// Top level of the source text lexer: input stream, lexer core, output queue.
//
// Usage: one source byte per word on the s_ side; s_tlast marks the end of
// the stream (the byte is then ignored) and flushes the pending token. Tokens
// leave on the m_ side, class in m_tuser, position and size in m_tdata;
// m_tlast flags the last token caused by one input word.
// A token goes out when its end is known: on the byte after it, or with the
// bracket byte itself. A token is written into the output queue at the accepting
// edge, and m_tvalid is taken from the queue count. Throughput is one byte per
// cycle while s_tready is high; a byte that ends a run and is itself a bracket
// yields two tokens, both written at once into the four-entry output queue.
// s_tready is high while the queue holds at most two tokens; once a stalled
// receiver leaves three or four tokens waiting, input stops. Nothing is dropped.
// Reset clears the queue and returns the stream to offset 0, line 1; the end
// word returns the stream there too, after its flush, but keeps the queue.
module source_text_lexer import stl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] token_start, [47:32] token_length,
	                               // [63:48] line_number
	output logic [3:0]  m_tuser,   // [3:0] token_class
	output logic        m_tlast    // last_of_run
);

	localparam int QDEPTH = 4;
	localparam int QCW = $clog2(QDEPTH + 1);

	tok_t           q_q [QDEPTH];
	tok_t           q_n [QDEPTH];
	logic [QCW-1:0] cnt_q, cnt_n, pos;
	logic           s_acc, pop;
	slot_t          slot0, slot1;

	assign s_tready = (cnt_q <= QCW'(QDEPTH - 2));
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;

	stl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_acc),
		.char_code    (s_tdata),
		.end_of_input (s_tlast),
		.slot0        (slot0),
		.slot1        (slot1)
	);

	assign pos = cnt_q - {{(QCW-1){1'b0}}, pop};

	always_comb begin
		for (int i = 0; i < QDEPTH - 1; i++)
			q_n[i] = pop ? q_q[i+1] : q_q[i];
		q_n[QDEPTH-1] = q_q[QDEPTH-1];
		for (int i = 0; i < QDEPTH; i++) begin
			if (slot0.vld && (QCW'(i) == pos))
				q_n[i] = slot0.tok;
			if (slot1.vld && (QCW'(i) == pos + QCW'(1)))
				q_n[i] = slot1.tok;
		end
		cnt_n = pos + {{(QCW-1){1'b0}}, slot0.vld} + {{(QCW-1){1'b0}}, slot1.vld};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_n;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++)
			q_q[i] <= q_n[i];
	end

	assign m_tdata = {q_q[0].line_number, q_q[0].token_length, q_q[0].token_start};
	assign m_tuser = 4'(q_q[0].token_class);
	assign m_tlast = q_q[0].last_of_run;

endmodule

// File: sv/stl_chk.sv
// Port-level checker for the source text lexer, bound to the top level.
`include "source_text_lexer_defines.svh"

module stl_chk import stl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	`STL_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !m_tvalid, "token word after reset")
	`STL_ASSERT(a_out_hold, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast), "stalled token word changed")
	`STL_ASSERT(a_br_len, clk, arst_n,
		m_tvalid && (m_tuser == 4'(CLS_BRACKET)) |-> (m_tdata[47:32] == 16'd1) && m_tlast,
		"bracket token not one byte or not last")
	`STL_ASSERT(a_len_line, clk, arst_n,
		m_tvalid |-> (m_tdata[47:32] != 16'd0) && (m_tdata[63:48] != 16'd0),
		"zero token length or line")

endmodule

bind source_text_lexer stl_chk u_stl_chk (.*);
